/* src/pkvbt_pkg.sv */
// ----------------------------------------------------------------------------
// Paged key/value block table package
// Shared sizes, codes and the key/value memory request type.
// ----------------------------------------------------------------------------
package pkvbt_pkg;

    localparam int LAYERS     = 8;
    localparam int POOL_PAGES = 64;
    localparam int PAGE_SLOTS = 16;
    localparam int EMBED      = 64;

    localparam int LAYER_W  = 3;
    localparam int PAGE_W   = 6;
    localparam int SLOT_W   = 4;
    localparam int OFF_W    = 10;
    localparam int KV_AW    = PAGE_W + OFF_W;
    localparam int COUNT_W  = 7;
    localparam int FILL_W   = 5;
    localparam int POS_W    = 10;
    localparam int HIGH_W   = 11;
    localparam int WORD_W   = 32;

    localparam logic [1:0] ACT_STORE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_LAYER = 3'd1;
    localparam logic [2:0] ST_NO_PAGES  = 3'd2;
    localparam logic [2:0] ST_BAD_ELEM  = 3'd3;
    localparam logic [2:0] ST_UNMAPPED  = 3'd4;

    localparam logic REG_LAYER_COUNT = 1'b0;
    localparam logic REG_EMBED_LEN   = 1'b1;

    typedef struct packed {
        logic              we;
        logic [KV_AW-1:0]  addr;
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] value;
    } t_kv_req;

endpackage

/* src/pkvbt_kv_mem.sv */
// ----------------------------------------------------------------------------
// Key/value word memory
// Two single-port synchronous arrays sharing one address, with registered read data.
// ----------------------------------------------------------------------------
module pkvbt_kv_mem (
    input  logic                              i_clk,
    input  pkvbt_pkg::t_kv_req                i_req,
    output logic [pkvbt_pkg::WORD_W-1:0]      o_key,
    output logic [pkvbt_pkg::WORD_W-1:0]      o_value
);

    logic [pkvbt_pkg::WORD_W-1:0] key_mem   [2**pkvbt_pkg::KV_AW];
    logic [pkvbt_pkg::WORD_W-1:0] value_mem [2**pkvbt_pkg::KV_AW];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            key_mem[i_req.addr]   <= i_req.key;
            value_mem[i_req.addr] <= i_req.value;
        end
        o_key   <= key_mem[i_req.addr];
        o_value <= value_mem[i_req.addr];
    end

endmodule

/* src/paged_kv_block_table.sv */
// ----------------------------------------------------------------------------
// Paged key/value block table
// Per-layer page tables over a shared free-page stack with key/value storage.
// ----------------------------------------------------------------------------
// A transaction rejected or ignored on arrival answers in the cycle after it is
// taken; a store or read into a mapped page answers after the page-table wait and
// data states. A new page leaves the stack in alloc and alloc-read, then the zero
// sweep clears its 1024 key/value words one word a cycle and the page table is
// re-read. A clear visits each mapped page in clear-read and clear-write and each
// layer once more in clear-read. Throughput is one transaction at a time; busy
// shows this. Reset is synchronous and active low; the free stack reads as pages
// in order through per-entry valid bits, so no clearing pass is needed after reset.
module paged_kv_block_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [2:0]  i_layer,
    input  logic [9:0]  i_position,
    input  logic [5:0]  i_element,
    input  logic [31:0] i_key_word,
    input  logic [31:0] i_value_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    output logic        o_result_strobe,
    output logic [2:0]  o_status,
    output logic [31:0] o_read_key,
    output logic [31:0] o_read_value,
    output logic [5:0]  o_page_number,
    output logic [3:0]  o_slot,
    output logic [4:0]  o_page_fill,
    output logic [10:0] o_next_position,
    output logic [6:0]  o_free_pages
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PT_WAIT  = 4'd1;
    localparam logic [3:0] S_DATA     = 4'd2;
    localparam logic [3:0] S_ALLOC    = 4'd3;
    localparam logic [3:0] S_ALLOC_RD = 4'd4;
    localparam logic [3:0] S_ZERO     = 4'd5;
    localparam logic [3:0] S_PT_RD    = 4'd6;
    localparam logic [3:0] S_CLR_RD   = 4'd7;
    localparam logic [3:0] S_CLR_WR   = 4'd8;

    localparam logic [6:0] POOL_FULL = 7'(pkvbt_pkg::POOL_PAGES);
    localparam logic [3:0] LAYER_MAX = 4'(pkvbt_pkg::LAYERS);
    localparam logic [6:0] EMBED_MAX = 7'(pkvbt_pkg::EMBED);
    localparam logic [2:0] LAST_LAYER = 3'(pkvbt_pkg::LAYERS - 1);
    localparam logic [9:0] LAST_WORD = '1;

    // Control state and configuration.
    logic [3:0]  r_state, n_state;
    logic [3:0]  r_layers;
    logic [6:0]  r_embed;
    logic [6:0]  r_free_top, n_free_top;
    logic [10:0] r_high, n_high;
    logic [6:0]  r_lpc [pkvbt_pkg::LAYERS];
    logic [pkvbt_pkg::POOL_PAGES-1:0] r_fs_valid;

    // Latched transaction.
    logic [1:0]  r_act;
    logic [2:0]  r_ly;
    logic [9:0]  r_pos;
    logic [5:0]  r_el;
    logic [31:0] r_kw, r_vw;

    // Working registers.
    logic [5:0]  r_pg, n_pg;
    logic [9:0]  r_cnt, n_cnt;
    logic [2:0]  r_cl, n_cl;
    logic [6:0]  r_ci, n_ci;

    // Result registers.
    logic        r_strobe;
    logic [2:0]  r_status;
    logic [31:0] r_rkey, r_rval;
    logic [5:0]  r_rpnum;
    logic [3:0]  r_rslot;
    logic [4:0]  r_rfill;

    // Result produced this cycle.
    logic        res_fire;
    logic [2:0]  res_status;
    logic [31:0] res_key, res_val;
    logic [5:0]  res_pnum;
    logic [3:0]  res_slot;
    logic [4:0]  res_fill;

    // Memory ports.
    logic [5:0]  pt_mem [pkvbt_pkg::LAYERS * pkvbt_pkg::POOL_PAGES];
    logic [8:0]  pt_ra, pt_wa;
    logic        pt_we;
    logic [5:0]  pt_wd, r_pt_q;

    logic [5:0]  fs_mem [pkvbt_pkg::POOL_PAGES];
    logic [5:0]  fs_ra, fs_wa, fs_wd, r_fs_q, r_fs_ra;
    logic        fs_we, r_fs_v;

    logic [4:0]  fc_mem [pkvbt_pkg::POOL_PAGES];
    logic [5:0]  fc_ra, fc_wa;
    logic        fc_we;
    logic [4:0]  fc_wd, r_fc_q;

    pkvbt_pkg::t_kv_req kv_req;
    logic [31:0] kv_key, kv_val;

    // Derived values.
    logic [3:0]  eff_layers;
    logic [6:0]  eff_embed;
    logic [5:0]  lpage;
    logic [3:0]  slot;
    logic [10:0] prod;
    logic [9:0]  word_off;
    logic [4:0]  new_fill;
    logic [10:0] pos_next;
    logic [5:0]  alloc_pg;
    logic        lpc_inc, lpc_clr;

    assign eff_layers = (r_layers > LAYER_MAX) ? LAYER_MAX : r_layers;
    assign eff_embed  = (r_embed > EMBED_MAX) ? EMBED_MAX : r_embed;
    assign lpage      = r_pos[9:4];
    assign slot       = r_pos[3:0];
    assign prod       = 11'(slot) * 11'(eff_embed) + 11'(r_el);
    assign word_off   = prod[9:0];
    assign new_fill   = (r_fc_q < (5'(slot) + 5'd1)) ? (5'(slot) + 5'd1) : r_fc_q;
    assign pos_next   = 11'(r_pos) + 11'd1;
    assign alloc_pg   = r_fs_v ? r_fs_q : r_fs_ra;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    pkvbt_kv_mem u_kv_mem (
        .i_clk   (i_clk),
        .i_req   (kv_req),
        .o_key   (kv_key),
        .o_value (kv_val)
    );

    always_comb begin
        n_state    = r_state;
        n_free_top = r_free_top;
        n_high     = r_high;
        n_pg       = r_pg;
        n_cnt      = r_cnt;
        n_cl       = r_cl;
        n_ci       = r_ci;
        lpc_inc    = 1'b0;
        lpc_clr    = 1'b0;
        res_fire   = 1'b0;
        res_status = pkvbt_pkg::ST_OK;
        res_key    = '0;
        res_val    = '0;
        res_pnum   = '0;
        res_slot   = '0;
        res_fill   = '0;
        pt_ra      = {r_ly, lpage};
        pt_we      = 1'b0;
        pt_wa      = {r_ly, r_lpc[r_ly][5:0]};
        pt_wd      = alloc_pg;
        fs_ra      = 6'(r_free_top - 7'd1);
        fs_we      = 1'b0;
        fs_wa      = r_free_top[5:0];
        fs_wd      = r_pt_q;
        fc_ra      = r_pt_q;
        fc_we      = 1'b0;
        fc_wa      = r_pg;
        fc_wd      = new_fill;
        kv_req.we    = 1'b0;
        kv_req.addr  = {r_pt_q, word_off};
        kv_req.key   = r_kw;
        kv_req.value = r_vw;

        unique case (r_state)
            S_IDLE: begin
                // The page table read goes out speculatively on every transaction.
                pt_ra = {i_layer, i_position[9:4]};
                if (start) begin
                    res_slot = i_position[3:0];
                    priority if (i_action == pkvbt_pkg::ACT_CLEAR) begin
                        res_slot = '0;
                        n_high   = '0;
                        n_cl     = '0;
                        n_ci     = '0;
                        n_state  = S_CLR_RD;
                    end else if (i_action != pkvbt_pkg::ACT_STORE &&
                                 i_action != pkvbt_pkg::ACT_READ) begin
                        res_slot = '0;
                        res_fire = 1'b1;
                    end else if ({1'b0, i_layer} >= eff_layers) begin
                        res_status = pkvbt_pkg::ST_BAD_LAYER;
                        res_fire   = 1'b1;
                    end else if ({1'b0, i_element} >= eff_embed) begin
                        res_status = pkvbt_pkg::ST_BAD_ELEM;
                        res_fire   = 1'b1;
                    end else if (i_action == pkvbt_pkg::ACT_STORE) begin
                        if (r_lpc[i_layer] <= {1'b0, i_position[9:4]}) begin
                            n_state = S_ALLOC;
                        end else begin
                            n_state = S_PT_WAIT;
                        end
                    end else if ({1'b0, i_position[9:4]} >= r_lpc[i_layer]) begin
                        res_status = pkvbt_pkg::ST_UNMAPPED;
                        res_fire   = 1'b1;
                    end else begin
                        n_state = S_PT_WAIT;
                    end
                end
            end
            S_PT_RD: begin
                n_state = S_PT_WAIT;
            end
            S_PT_WAIT: begin
                n_pg    = r_pt_q;
                n_state = S_DATA;
            end
            S_DATA: begin
                res_fire = 1'b1;
                res_slot = slot;
                res_pnum = r_pg;
                n_state  = S_IDLE;
                if (r_act == pkvbt_pkg::ACT_STORE) begin
                    kv_req.we   = 1'b1;
                    kv_req.addr = {r_pg, word_off};
                    fc_we       = 1'b1;
                    res_fill    = new_fill;
                    if (r_high < pos_next) begin
                        n_high = pos_next;
                    end
                end else begin
                    res_key  = kv_key;
                    res_val  = kv_val;
                    res_fill = r_fc_q;
                end
            end
            S_ALLOC: begin
                if (r_free_top == '0 || r_lpc[r_ly] >= POOL_FULL) begin
                    res_fire   = 1'b1;
                    res_status = pkvbt_pkg::ST_NO_PAGES;
                    res_slot   = slot;
                    n_state    = S_IDLE;
                end else begin
                    n_free_top = r_free_top - 7'd1;
                    n_state    = S_ALLOC_RD;
                end
            end
            S_ALLOC_RD: begin
                pt_we   = 1'b1;
                lpc_inc = 1'b1;
                fc_we   = 1'b1;
                fc_wa   = alloc_pg;
                fc_wd   = '0;
                n_pg    = alloc_pg;
                n_cnt   = '0;
                n_state = S_ZERO;
            end
            S_ZERO: begin
                kv_req.we    = 1'b1;
                kv_req.addr  = {r_pg, r_cnt};
                kv_req.key   = '0;
                kv_req.value = '0;
                n_cnt        = r_cnt + 10'd1;
                if (r_cnt == LAST_WORD) begin
                    n_state = (r_lpc[r_ly] <= {1'b0, lpage}) ? S_ALLOC : S_PT_RD;
                end
            end
            S_CLR_RD: begin
                pt_ra = {r_cl, r_ci[5:0]};
                if (r_ci < r_lpc[r_cl]) begin
                    n_state = S_CLR_WR;
                end else begin
                    lpc_clr = 1'b1;
                    n_ci    = '0;
                    if (r_cl == LAST_LAYER) begin
                        res_fire = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_cl = r_cl + 3'd1;
                    end
                end
            end
            S_CLR_WR: begin
                if (r_free_top < POOL_FULL) begin
                    fs_we      = 1'b1;
                    n_free_top = r_free_top + 7'd1;
                end
                n_ci    = r_ci + 7'd1;
                n_state = S_CLR_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_layers   <= 4'd8;
            r_embed    <= 7'd64;
            r_free_top <= POOL_FULL;
            r_high     <= '0;
            r_fs_valid <= '0;
            r_strobe   <= 1'b0;
            r_cnt      <= '0;
            r_cl       <= '0;
            r_ci       <= '0;
            for (int l = 0; l < pkvbt_pkg::LAYERS; l++) begin
                r_lpc[l] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_free_top <= n_free_top;
            r_high     <= n_high;
            r_strobe   <= res_fire;
            r_cnt      <= n_cnt;
            r_cl       <= n_cl;
            r_ci       <= n_ci;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == pkvbt_pkg::REG_LAYER_COUNT) begin
                    r_layers <= i_cfg_data[3:0];
                end else begin
                    r_embed <= i_cfg_data;
                end
            end
            if (fs_we) begin
                r_fs_valid[fs_wa] <= 1'b1;
            end
            if (lpc_inc) begin
                r_lpc[r_ly] <= r_lpc[r_ly] + 7'd1;
            end
            if (lpc_clr) begin
                r_lpc[r_cl] <= '0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pg <= n_pg;
        if (start && !busy) begin
            r_act <= i_action;
            r_ly  <= i_layer;
            r_pos <= i_position;
            r_el  <= i_element;
            r_kw  <= i_key_word;
            r_vw  <= i_value_word;
        end
        if (res_fire) begin
            r_status <= res_status;
            r_rkey   <= res_key;
            r_rval   <= res_val;
            r_rpnum  <= res_pnum;
            r_rslot  <= res_slot;
            r_rfill  <= res_fill;
        end
    end

    // Page table, free stack and fill count memories.
    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            pt_mem[pt_wa] <= pt_wd;
        end
        r_pt_q <= pt_mem[pt_ra];
        if (fs_we) begin
            fs_mem[fs_wa] <= fs_wd;
        end
        r_fs_q  <= fs_mem[fs_ra];
        r_fs_v  <= r_fs_valid[fs_ra];
        r_fs_ra <= fs_ra;
        if (fc_we) begin
            fc_mem[fc_wa] <= fc_wd;
        end
        r_fc_q <= fc_mem[fc_ra];
    end

    assign o_result_strobe = r_strobe;
    assign o_status        = r_status;
    assign o_read_key      = r_rkey;
    assign o_read_value    = r_rval;
    assign o_page_number   = r_rpnum;
    assign o_slot          = r_rslot;
    assign o_page_fill     = r_rfill;
    assign o_next_position = r_high;
    assign o_free_pages    = r_free_top;

`ifndef NO_ASSERTIONS
    logic [9:0] page_total;
    always_comb begin
        page_total = 10'(r_free_top);
        for (int l = 0; l < pkvbt_pkg::LAYERS; l++) begin
            page_total = page_total + 10'(r_lpc[l]);
        end
    end

    // Pages are conserved between the pool and the layers whenever idle.
    a_pages_conserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (page_total == 10'(pkvbt_pkg::POOL_PAGES)))
        else $error("page count not conserved");

    // A result is only presented once the block has returned to idle.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_state == S_IDLE))
        else $error("result strobe while busy");

    // The zero sweep counter always finishes a full page.
    a_sweep_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ZERO) |-> (r_cnt == '0))
        else $error("zero sweep left incomplete");

    // The free stack never grows beyond the pool.
    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_top <= POOL_FULL)
        else $error("free stack overflow");
`endif

endmodule
